// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of ck while the active-low reset rn is released.
`define ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Check prop on every rising edge of ck, reset included.
`define ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

// ----- rtl/acc_pkg.sv -----
package acc_pkg;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_KEY  = 1'b1
    } opcode_t;

    localparam logic [7:0] KEY_NONE   = 8'h00;
    localparam logic [7:0] KEY_MODE   = 8'h43;  // C
    localparam logic [7:0] KEY_ROW    = 8'h41;  // A
    localparam logic [7:0] KEY_COLUMN = 8'h42;  // B
    localparam logic [7:0] KEY_UP     = 8'h51;  // Q
    localparam logic [7:0] KEY_DOWN   = 8'h57;  // W

    localparam logic [15:0] TPS_RESET  = 16'd1000;
    localparam logic [5:0]  HOUR_LIMIT = 6'd24;
    localparam logic [5:0]  MIN_LIMIT  = 6'd60;
    localparam logic [5:0]  RING_LAST  = 6'd30;

    localparam logic [5:0]  SEC_RESET        = 6'd42;
    localparam logic [5:0]  MIN_RESET        = 6'd29;
    localparam logic [4:0]  HOUR_RESET       = 5'd7;
    localparam logic [5:0]  ALARM_MIN_RESET  = 6'd30;
    localparam logic [4:0]  ALARM_HOUR_RESET = 5'd7;

    // Edit row / column codes
    localparam logic ROW_TIME   = 1'b0;
    localparam logic COL_HOUR   = 1'b0;

    // Advance with wrap at limit.
    function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] limit);
        logic [6:0] s;
        s = {1'b0, v} + 7'd1;
        return (s >= {1'b0, limit}) ? 6'd0 : s[5:0];
    endfunction

    // Step back with wrap; out-of-range values land on limit - 1.
    function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] limit);
        return (v == 6'd0 || v >= limit) ? (limit - 6'd1) : (v - 6'd1);
    endfunction

endpackage

// ----- rtl/alarm_clock_controller_core.sv -----
// Alarm clock controller core. Each input item is a millisecond tick
// (opcode 0) or a key press (opcode 1, ASCII key_code), and each item yields
// exactly one result item carrying the full clock state after that item:
// time, alarm setting, edit mode/row/column, ringing flag, second LED and the
// digit-select scan lines. The block takes one item per clock cycle while
// the result is drained; an accepted item is held in the input register and
// is written into the result register once the result slot is free. The
// clock state is updated in a single combinational pass between those
// registers. A stalled result holds the pipe; in_ready drops only when both
// the input register and the result register are full and out_ready is low.
// ticks_per_second is written through the cfg port (cfg_ready is always high)
// and counts ticks per second; a value of zero makes every tick a second.
// Reset brings the time to 07:29:42 and the alarm to 07:30. Key code zero is
// "no key" and changes nothing.
`include "assert_macros.svh"

module alarm_clock_controller_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  key_code,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  hours,
    output logic [5:0]  minutes,
    output logic [5:0]  seconds,
    output logic [4:0]  alarm_hours,
    output logic [5:0]  alarm_minutes,
    output logic        setting_mode,
    output logic        edit_row,
    output logic        edit_column,
    output logic        alarm_ringing,
    output logic        second_led,
    output logic [2:0]  digit_select
);

    // Configuration
    logic [15:0] tps_reg;

    // Input register
    logic             in_valid_reg;
    acc_pkg::opcode_t op_reg;
    logic [7:0]       key_reg;

    // Clock state
    logic [15:0] tick_reg,       tick_next;
    logic [5:0]  sec_reg,        sec_next;
    logic [5:0]  min_reg,        min_next;
    logic [4:0]  hour_reg,       hour_next;
    logic [5:0]  alarm_min_reg,  alarm_min_next;
    logic [4:0]  alarm_hour_reg, alarm_hour_next;
    logic        mode_reg,       mode_next;
    logic        row_reg,        row_next;
    logic        column_reg,     column_next;
    logic        ring_reg,       ring_next;
    logic        led_reg,        led_next;
    logic [2:0]  scan_reg,       scan_next;

    // Result register
    logic        out_valid_reg;
    logic [4:0]  hours_reg;
    logic [5:0]  minutes_reg;
    logic [5:0]  seconds_reg;
    logic [4:0]  alarm_hours_reg;
    logic [5:0]  alarm_minutes_reg;
    logic        mode_out_reg;
    logic        row_out_reg;
    logic        column_out_reg;
    logic        ring_out_reg;
    logic        led_out_reg;
    logic [2:0]  digit_reg;

    logic        advance;
    logic [15:0] tick_inc;
    logic [5:0]  sec_inc;
    logic [5:0]  min_inc;
    logic [5:0]  hour_wrap;
    logic [5:0]  field_sel;
    logic [5:0]  field_limit;
    logic [5:0]  field_up;
    logic [5:0]  field_down;

    // Process the held item when the result slot is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= acc_pkg::TPS_RESET;
        end
        else if (cfg_valid)
        begin
            tps_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= acc_pkg::opcode_t'(opcode);
            key_reg <= key_code;
        end
    end

    // Edit field selected by the current row and column
    always_comb
    begin
        if (row_reg == acc_pkg::ROW_TIME)
        begin
            field_sel = (column_reg == acc_pkg::COL_HOUR) ? {1'b0, hour_reg} : min_reg;
        end
        else
        begin
            field_sel = (column_reg == acc_pkg::COL_HOUR) ? {1'b0, alarm_hour_reg}
                                                          : alarm_min_reg;
        end
        field_limit = (column_reg == acc_pkg::COL_HOUR) ? acc_pkg::HOUR_LIMIT
                                                        : acc_pkg::MIN_LIMIT;
    end

    assign field_up   = acc_pkg::wrap_up(field_sel, field_limit);
    assign field_down = acc_pkg::wrap_down(field_sel, field_limit);

    assign tick_inc  = tick_reg + 16'd1;
    assign sec_inc   = sec_reg + 6'd1;
    assign min_inc   = min_reg + 6'd1;
    assign hour_wrap = acc_pkg::wrap_up({1'b0, hour_reg}, acc_pkg::HOUR_LIMIT);

    // Next clock state for the held item
    always_comb
    begin
        tick_next       = tick_reg;
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        alarm_min_next  = alarm_min_reg;
        alarm_hour_next = alarm_hour_reg;
        mode_next       = mode_reg;
        row_next        = row_reg;
        column_next     = column_reg;
        ring_next       = ring_reg;
        led_next        = led_reg;
        scan_next       = scan_reg;

        if (op_reg == acc_pkg::OP_TICK)
        begin
            if (tick_inc < tps_reg)
            begin
                tick_next = tick_inc;
            end
            else
            begin
                // One second elapsed: toggle the LED, step the scan, carry.
                tick_next = 16'd0;
                led_next  = !led_reg;
                scan_next = scan_reg + 3'd1;
                if (sec_inc >= acc_pkg::MIN_LIMIT)
                begin
                    sec_next = 6'd0;
                    if (min_inc >= acc_pkg::MIN_LIMIT)
                    begin
                        min_next  = 6'd0;
                        hour_next = hour_wrap[4:0];
                    end
                    else
                    begin
                        min_next = min_inc;
                    end
                end
                else
                begin
                    sec_next = sec_inc;
                end
                if (alarm_hour_reg == hour_next && alarm_min_reg == min_next
                    && sec_next == 6'd0)
                begin
                    ring_next = 1'b1;
                end
            end
        end
        else if (key_reg != acc_pkg::KEY_NONE)
        begin
            mode_next = mode_reg ^ (key_reg == acc_pkg::KEY_MODE);
            if (mode_next)
            begin
                case (key_reg)
                    acc_pkg::KEY_ROW:    row_next    = !row_reg;
                    acc_pkg::KEY_COLUMN: column_next = !column_reg;
                    acc_pkg::KEY_UP, acc_pkg::KEY_DOWN:
                    begin
                        if (row_reg == acc_pkg::ROW_TIME)
                        begin
                            if (column_reg == acc_pkg::COL_HOUR)
                            begin
                                hour_next = (key_reg == acc_pkg::KEY_UP) ? field_up[4:0]
                                                                         : field_down[4:0];
                            end
                            else
                            begin
                                min_next = (key_reg == acc_pkg::KEY_UP) ? field_up
                                                                        : field_down;
                            end
                        end
                        else
                        begin
                            if (column_reg == acc_pkg::COL_HOUR)
                            begin
                                alarm_hour_next = (key_reg == acc_pkg::KEY_UP)
                                                  ? field_up[4:0] : field_down[4:0];
                            end
                            else
                            begin
                                alarm_min_next = (key_reg == acc_pkg::KEY_UP)
                                                 ? field_up : field_down;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            // Any key silences the alarm.
            ring_next = 1'b0;
        end

        // Drop the alarm once past the half minute.
        if (ring_next && sec_next > acc_pkg::RING_LAST)
        begin
            ring_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= 16'd0;
            sec_reg        <= acc_pkg::SEC_RESET;
            min_reg        <= acc_pkg::MIN_RESET;
            hour_reg       <= acc_pkg::HOUR_RESET;
            alarm_min_reg  <= acc_pkg::ALARM_MIN_RESET;
            alarm_hour_reg <= acc_pkg::ALARM_HOUR_RESET;
            mode_reg       <= 1'b0;
            row_reg        <= 1'b0;
            column_reg     <= 1'b0;
            ring_reg       <= 1'b0;
            led_reg        <= 1'b0;
            scan_reg       <= 3'd0;
        end
        else if (advance)
        begin
            tick_reg       <= tick_next;
            sec_reg        <= sec_next;
            min_reg        <= min_next;
            hour_reg       <= hour_next;
            alarm_min_reg  <= alarm_min_next;
            alarm_hour_reg <= alarm_hour_next;
            mode_reg       <= mode_next;
            row_reg        <= row_next;
            column_reg     <= column_next;
            ring_reg       <= ring_next;
            led_reg        <= led_next;
            scan_reg       <= scan_next;
        end
    end

    // Result register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register: snapshot of the state after the item
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hours_reg         <= hour_next;
            minutes_reg       <= min_next;
            seconds_reg       <= sec_next;
            alarm_hours_reg   <= alarm_hour_next;
            alarm_minutes_reg <= alarm_min_next;
            mode_out_reg      <= mode_next;
            row_out_reg       <= row_next;
            column_out_reg    <= column_next;
            ring_out_reg      <= ring_next;
            led_out_reg       <= led_next;
            digit_reg         <= ~scan_next;  // 7 minus scan position
        end
    end

    assign out_valid     = out_valid_reg;
    assign hours         = hours_reg;
    assign minutes       = minutes_reg;
    assign seconds       = seconds_reg;
    assign alarm_hours   = alarm_hours_reg;
    assign alarm_minutes = alarm_minutes_reg;
    assign setting_mode  = mode_out_reg;
    assign edit_row      = row_out_reg;
    assign edit_column   = column_out_reg;
    assign alarm_ringing = ring_out_reg;
    assign second_led    = led_out_reg;
    assign digit_select  = digit_reg;

    // Assertions
    `ASSERT_CLK(a_time_in_range, clk, rst_n,
        hour_reg < 5'd24 && min_reg < 6'd60 && sec_reg < 6'd60
        && alarm_hour_reg < 5'd24 && alarm_min_reg < 6'd60,
        "clock or alarm field out of range")

    `ASSERT_CLK(a_stall_only_when_full, clk, rst_n,
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready),
        "input stalled while the pipe can move")

    `ASSERT_CLK(a_ring_window, clk, rst_n,
        (out_valid && alarm_ringing) |-> (seconds <= 6'd30),
        "alarm reported ringing past the half minute")

    `ASSERT_CLK(a_state_holds_idle, clk, rst_n,
        !$past(advance) |-> ($stable(tick_reg) && $stable(sec_reg) && $stable(scan_reg)),
        "clock state moved without an item")

endmodule
